// ----- hdl/wavhp_pkg.sv -----
package wavhp_pkg;

    localparam int unsigned DataLenW = 31;
    localparam int unsigned ChanW    = 16;

    localparam logic [ChanW-1:0] CHAN_RESET = 16'd2;

    // Tags as they read once four little-endian bytes have been shifted in.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;

    localparam logic [31:0] MIN_FMT_SIZE = 32'd16;
    localparam logic [15:0] PCM_FORMAT   = 16'd1;

    // Parser stages.
    localparam logic [3:0] ST_RIFF_TAG  = 4'd0;
    localparam logic [3:0] ST_RIFF_SIZE = 4'd1;
    localparam logic [3:0] ST_WAVE_TAG  = 4'd2;
    localparam logic [3:0] ST_FMT_TAG   = 4'd3;
    localparam logic [3:0] ST_FMT_SIZE  = 4'd4;
    localparam logic [3:0] ST_FORMAT    = 4'd5;
    localparam logic [3:0] ST_CHANNELS  = 4'd6;
    localparam logic [3:0] ST_FMT_SKIP  = 4'd7;
    localparam logic [3:0] ST_CHUNK_TAG = 4'd8;
    localparam logic [3:0] ST_CHUNK_LEN = 4'd9;
    localparam logic [3:0] ST_FACT_SKIP = 4'd10;
    localparam logic [3:0] ST_PAYLOAD   = 4'd11;
    localparam logic [3:0] ST_REJECT    = 4'd12;

    // Result phases.
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_REJECT  = 2'd2;

    // Error kinds.
    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_NO_RIFF = 4'd1;
    localparam logic [3:0] ERR_NO_WAVE = 4'd2;
    localparam logic [3:0] ERR_NO_FMT  = 4'd3;
    localparam logic [3:0] ERR_FMT_SZ  = 4'd4;
    localparam logic [3:0] ERR_NOT_PCM = 4'd5;
    localparam logic [3:0] ERR_CHAN    = 4'd6;
    localparam logic [3:0] ERR_UNKNOWN = 4'd7;
    localparam logic [3:0] ERR_TRUNC   = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       file_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          phase;
        logic [3:0]          error_kind;
        logic [DataLenW-1:0] data_length;
        logic [7:0]          payload_byte;
    } t_result;

endpackage

// ----- hdl/wavhp_in_reg.sv -----
module wavhp_in_reg
    import wavhp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register frees up in the same cycle its item moves on.
    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hdl/wavhp_core.sv -----
module wavhp_core
    import wavhp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ChanW-1:0] i_cfg_data,
    input  logic             i_adv,
    input  t_in_item         i_item,
    output t_result          o_res
);

    logic [ChanW-1:0]    r_req_ch;
    logic [3:0]          r_stage,    n_stage,    c_stage;
    logic [1:0]          r_cnt,      n_cnt,      c_cnt;
    logic [31:0]         r_shift,    n_shift,    c_shift;
    logic [DataLenW-1:0] r_fmt_size, n_fmt_size, c_fmt_size;
    logic [DataLenW-1:0] r_skip,     n_skip,     c_skip;
    logic [31:0]         r_tag,      n_tag,      c_tag;
    logic [DataLenW-1:0] r_dlen,     n_dlen,     c_dlen;
    logic [3:0]          r_err,      n_err,      c_err;

    logic [31:0]         w_shift;
    logic [2:0]          w_cnt_inc;
    logic                w_done4;
    logic                w_done2;
    logic [1:0]          w_cnt4;
    logic [1:0]          w_cnt2;
    logic [DataLenW-1:0] w_skip_dec;
    logic [1:0]          w_phase;
    logic [7:0]          w_payload;

    // A file start restarts parsing with the current byte as the first.
    always_comb begin
        if (i_item.file_start) begin
            c_stage    = ST_RIFF_TAG;
            c_cnt      = '0;
            c_shift    = '0;
            c_fmt_size = '0;
            c_skip     = '0;
            c_tag      = '0;
            c_dlen     = '0;
            c_err      = ERR_NONE;
        end else begin
            c_stage    = r_stage;
            c_cnt      = r_cnt;
            c_shift    = r_shift;
            c_fmt_size = r_fmt_size;
            c_skip     = r_skip;
            c_tag      = r_tag;
            c_dlen     = r_dlen;
            c_err      = r_err;
        end
    end

    assign w_shift    = {i_item.data_byte, c_shift[31:8]};
    assign w_cnt_inc  = {1'b0, c_cnt} + 3'd1;
    assign w_done4    = (w_cnt_inc >= 3'd4);
    assign w_done2    = (w_cnt_inc >= 3'd2);
    assign w_cnt4     = w_done4 ? 2'd0 : w_cnt_inc[1:0];
    assign w_cnt2     = w_done2 ? 2'd0 : w_cnt_inc[1:0];
    assign w_skip_dec = c_skip - {{(DataLenW-1){1'b0}}, (c_skip != '0)};

    always_comb begin
        n_stage    = c_stage;
        n_cnt      = c_cnt;
        n_shift    = c_shift;
        n_fmt_size = c_fmt_size;
        n_skip     = c_skip;
        n_tag      = c_tag;
        n_dlen     = c_dlen;
        n_err      = c_err;
        w_phase    = PH_HEADER;
        w_payload  = 8'd0;
        unique case (c_stage)
            ST_PAYLOAD: begin
                w_phase   = PH_PAYLOAD;
                w_payload = i_item.data_byte;
            end
            ST_RIFF_TAG, ST_RIFF_SIZE, ST_CHUNK_TAG: begin
                n_shift = w_shift;
                n_cnt   = w_cnt4;
                if (w_done4) begin
                    if (c_stage == ST_RIFF_SIZE) begin
                        n_stage = ST_WAVE_TAG;
                    end else begin
                        n_tag   = w_shift;
                        n_stage = (c_stage == ST_RIFF_TAG) ? ST_RIFF_SIZE : ST_CHUNK_LEN;
                    end
                end
            end
            ST_WAVE_TAG: begin
                n_shift = w_shift;
                n_cnt   = w_cnt4;
                if (w_done4) begin
                    if (c_tag != TAG_RIFF) begin
                        n_err   = ERR_NO_RIFF;
                        n_stage = ST_REJECT;
                    end else if (w_shift != TAG_WAVE) begin
                        n_err   = ERR_NO_WAVE;
                        n_stage = ST_REJECT;
                    end else begin
                        n_stage = ST_FMT_TAG;
                    end
                end
            end
            ST_FMT_TAG: begin
                n_shift = w_shift;
                n_cnt   = w_cnt4;
                if (w_done4) begin
                    if (w_shift != TAG_FMT) begin
                        n_err   = ERR_NO_FMT;
                        n_stage = ST_REJECT;
                    end else begin
                        n_stage = ST_FMT_SIZE;
                    end
                end
            end
            ST_FMT_SIZE: begin
                n_shift = w_shift;
                n_cnt   = w_cnt4;
                if (w_done4) begin
                    if (w_shift[31] || (w_shift < MIN_FMT_SIZE)) begin
                        n_err   = ERR_FMT_SZ;
                        n_stage = ST_REJECT;
                    end else begin
                        n_fmt_size = w_shift[DataLenW-1:0];
                        n_stage    = ST_FORMAT;
                    end
                end
            end
            ST_FORMAT: begin
                n_shift = w_shift;
                n_cnt   = w_cnt2;
                if (w_done2) begin
                    if (w_shift[31:16] != PCM_FORMAT) begin
                        n_err   = ERR_NOT_PCM;
                        n_stage = ST_REJECT;
                    end else begin
                        n_stage = ST_CHANNELS;
                    end
                end
            end
            ST_CHANNELS: begin
                n_shift = w_shift;
                n_cnt   = w_cnt2;
                if (w_done2) begin
                    if (w_shift[31:16] != r_req_ch) begin
                        n_err   = ERR_CHAN;
                        n_stage = ST_REJECT;
                    end else begin
                        // Channel count and format code are already consumed.
                        n_skip  = c_fmt_size - DataLenW'(4);
                        n_stage = ST_FMT_SKIP;
                    end
                end
            end
            ST_FMT_SKIP, ST_FACT_SKIP: begin
                n_skip = w_skip_dec;
                if (w_skip_dec == '0) begin
                    n_stage = ST_CHUNK_TAG;
                end
            end
            ST_CHUNK_LEN: begin
                n_shift = w_shift;
                n_cnt   = w_cnt4;
                if (w_done4) begin
                    if ((c_tag == TAG_DATA) || (c_tag == TAG_FACT)) begin
                        if (w_shift[31]) begin
                            n_err   = ERR_TRUNC;
                            n_stage = ST_REJECT;
                        end else if (c_tag == TAG_DATA) begin
                            n_dlen  = w_shift[DataLenW-1:0];
                            n_stage = ST_PAYLOAD;
                        end else if (w_shift == '0) begin
                            n_stage = ST_CHUNK_TAG;
                        end else begin
                            n_skip  = w_shift[DataLenW-1:0];
                            n_stage = ST_FACT_SKIP;
                        end
                    end else begin
                        n_err   = ERR_UNKNOWN;
                        n_stage = ST_REJECT;
                    end
                end
            end
            default: begin
                n_stage = ST_REJECT;
                if (c_err == ERR_NONE) begin
                    n_err = ERR_TRUNC;
                end
            end
        endcase

        // A file that ends before its data chunk header is complete is truncated.
        if (i_item.file_end && (n_stage != ST_PAYLOAD) && (n_stage != ST_REJECT)) begin
            n_err   = ERR_TRUNC;
            n_stage = ST_REJECT;
        end
    end

    always_comb begin
        o_res.data_length = n_dlen;
        if (n_stage == ST_REJECT) begin
            o_res.phase        = PH_REJECT;
            o_res.error_kind   = n_err;
            o_res.payload_byte = 8'd0;
        end else begin
            o_res.phase        = w_phase;
            o_res.error_kind   = ERR_NONE;
            o_res.payload_byte = w_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_ch <= CHAN_RESET;
        end else if (i_cfg_we) begin
            r_req_ch <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= ST_RIFF_TAG;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_fmt_size <= '0;
            r_skip     <= '0;
            r_tag      <= '0;
            r_dlen     <= '0;
            r_err      <= ERR_NONE;
        end else if (i_adv) begin
            r_stage    <= n_stage;
            r_cnt      <= n_cnt;
            r_shift    <= n_shift;
            r_fmt_size <= n_fmt_size;
            r_skip     <= n_skip;
            r_tag      <= n_tag;
            r_dlen     <= n_dlen;
            r_err      <= n_err;
        end
    end

    a_reject_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.phase == PH_REJECT) |-> (o_res.error_kind != ERR_NONE))
        else $error("rejected result carries no error kind");

    a_error_only_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.phase != PH_REJECT) |-> (o_res.error_kind == ERR_NONE))
        else $error("error kind reported outside a rejected result");

    a_state_holds_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_stage) && $stable(r_err) && $stable(r_dlen)))
        else $error("parser state moved without an item advancing");

    a_payload_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (r_stage == ST_PAYLOAD) && !i_item.file_start)
            |-> (o_res.phase == PH_PAYLOAD))
        else $error("payload stage produced a non-payload result");

endmodule

// ----- hdl/wavhp_out_reg.sv -----
module wavhp_out_reg
    import wavhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_adv,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // An item moves in when the held result is empty or taken this cycle.
    assign o_adv   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- hdl/wav_header_parser_top.sv -----
// WAV header parser: takes a file one byte per item and checks the RIFF/WAVE
// header (RIFF and WAVE tags, "fmt " chunk with PCM format and the channel
// count held in the configuration register, optional fact chunks), then passes
// every byte after the data chunk header through as payload. Each input item
// yields exactly one result item, presented on the output once it has passed
// the input register and the core, and held there until it is taken: the byte
// sits in an input register, the parser computes its result combinationally
// and updates its state as the result lands in an output register. One item
// is accepted every cycle while the output side keeps taking results. A
// rejected file keeps answering with its error kind until an item with the
// file start flag arrives. The channel register resets to 2; the user must
// write it only while no item is in flight. The block does not enforce this.
module wav_header_parser_top
    import wavhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_wr_en,
    input  logic [ChanW-1:0]    i_cfg_wr_data,   // required_channels

    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,  // [7:0] data_byte
    input  logic                i_s_axis_tuser,  // [0] file_start
    input  logic                i_s_axis_tlast,  // file_end

    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [39:0]         o_m_axis_tdata,  // [30:0] data_length, [38:31] payload_byte
    output logic [5:0]          o_m_axis_tuser   // [1:0] phase, [5:2] error_kind
);

    t_in_item w_in_item;
    t_in_item w_reg_item;
    t_result  w_core_res;
    t_result  w_out_res;
    logic     w_reg_valid;
    logic     w_adv;

    assign w_in_item.data_byte  = i_s_axis_tdata;
    assign w_in_item.file_start = i_s_axis_tuser;
    assign w_in_item.file_end   = i_s_axis_tlast;

    wavhp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_in_item),
        .i_adv   (w_adv),
        .o_valid (w_reg_valid),
        .o_item  (w_reg_item)
    );

    wavhp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_wr_en),
        .i_cfg_data (i_cfg_wr_data),
        .i_adv      (w_adv),
        .i_item     (w_reg_item),
        .o_res      (w_core_res)
    );

    wavhp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_reg_valid),
        .i_res   (w_core_res),
        .o_adv   (w_adv),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out_res)
    );

    assign o_m_axis_tdata = {1'b0, w_out_res.payload_byte, w_out_res.data_length};
    assign o_m_axis_tuser = {w_out_res.error_kind, w_out_res.phase};

endmodule
